// ===== rtl/prqae_pkg.sv =====
// ----------------------------------------------------------------------------
// prqae_pkg
// Shared types, codes and defaults for the active/expired ready-queue block.
// ----------------------------------------------------------------------------
package prqae_pkg;

  localparam int DEF_LEVELS        = 16;
  localparam int DEF_MAX_PROCESSES = 256;

  // Field widths fixed by the word format
  localparam int ID_W     = 8;
  localparam int ID_SPACE = 256;
  localparam int PRIO_W   = 4;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0]  NUM_LEVELS_RESET = 5'd4;
  localparam logic signed [4:0] DYN_EXPIRED      = -5'sd1;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_GRANTED = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef enum logic {
    KIND_ADD  = 1'b0,
    KIND_TAKE = 1'b1
  } kind_t;

  // Update request to the level map
  typedef struct packed {
    logic set;
    logic clr;
    logic swap;
  } lvl_upd_t;

  // Bank occupancy seen by the sequencer
  typedef struct packed {
    logic act_empty;
    logic exp_empty;
  } lvl_sts_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    granted_id;
    logic [PRIO_W-1:0]  assigned_prio;
    logic               to_expired;
    logic               banks_swapped;
  } result_t;

endpackage

// ===== rtl/prqae_ram.sv =====
// ----------------------------------------------------------------------------
// prqae_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prqae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

// ===== rtl/prqae_level_map.sv =====
// ----------------------------------------------------------------------------
// prqae_level_map
// Nonempty marks per slot, active bank select and highest-level pick.
// ----------------------------------------------------------------------------
module prqae_level_map #(
  parameter int  LEVELS = prqae_pkg::DEF_LEVELS,
  localparam int SLOTS  = 2 * LEVELS,
  localparam int SLOT_W = $clog2(SLOTS),
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  prqae_pkg::lvl_upd_t upd,
  input  logic [SLOT_W-1:0]   upd_slot,
  output logic                active_bank,
  output logic                pop_bank,
  output logic [SLOTS-1:0]    nonempty,
  output prqae_pkg::lvl_sts_t sts,
  output logic [LVL_W-1:0]    pick_level
);

  logic [SLOTS-1:0]  nonempty_r;
  logic              active_r;
  logic [LEVELS-1:0] bank0_bits;
  logic [LEVELS-1:0] bank1_bits;
  logic [LEVELS-1:0] act_bits;
  logic [LEVELS-1:0] exp_bits;
  logic [LEVELS-1:0] pop_bits;

  assign bank0_bits = nonempty_r[LEVELS-1:0];
  assign bank1_bits = nonempty_r[SLOTS-1:LEVELS];
  assign act_bits   = active_r ? bank1_bits : bank0_bits;
  assign exp_bits   = active_r ? bank0_bits : bank1_bits;

  assign sts.act_empty = ~|act_bits;
  assign sts.exp_empty = ~|exp_bits;

  // Pop from the bank that is active once a pending swap is applied
  assign pop_bank = sts.act_empty ? ~active_r : active_r;
  assign pop_bits = pop_bank ? bank1_bits : bank0_bits;

  always_comb begin
    pick_level = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (pop_bits[l]) begin
        pick_level = LVL_W'(l);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r <= '0;
      active_r   <= 1'b0;
    end else begin
      if (upd.set) begin
        nonempty_r[upd_slot] <= 1'b1;
      end
      if (upd.clr) begin
        nonempty_r[upd_slot] <= 1'b0;
      end
      if (upd.swap) begin
        active_r <= ~active_r;
      end
    end
  end

  assign nonempty    = nonempty_r;
  assign active_bank = active_r;

endmodule

// ===== rtl/priority_ready_queue_active_expired_core.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue_active_expired_core
// Ready-queue scheduler: one FIFO per level in an active and an expired bank.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid/in_stall) either add a process id (kind add) or
//   take the next one (kind take). Each word yields exactly one result word
//   on out_valid/out_stall, in order.
//   An add with dynamic priority -1 goes to the expired bank at level
//   static-1; any other add goes to the active bank at its dynamic level.
//   Out-of-range levels come back as status "range" and change nothing.
//   A take pops the head of the highest nonempty active level, swapping the
//   banks first when the active bank is empty, or reports "empty".
// Steps (accept to result registered):
//   a rejected add or an empty take finishes in the accept step; an add
//   and a take of the last entry of a level finish after the head/tail
//   memory read; other takes then also wait for the link memory read of
//   the next head. Both memories have registered read data.
//   A new word is taken the cycle after the previous result is registered.
// Reset: nonempty marks clear, bank 0 becomes active, num_levels returns to
//   4. Head, tail and link memories are not cleared; no clearing pass.
// Stall: a result waits in the output register; one more word is processed
//   and its result is held internally until the output frees up.
// cfg_we/cfg_wdata write num_levels; write only while the block is idle.
// ----------------------------------------------------------------------------
module priority_ready_queue_active_expired_core #(
  parameter int LEVELS        = prqae_pkg::DEF_LEVELS,
  parameter int MAX_PROCESSES = prqae_pkg::DEF_MAX_PROCESSES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [prqae_pkg::CFG_W-1:0]   cfg_wdata,
  // input words
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [prqae_pkg::ID_W-1:0]    in_process_id,
  input  logic signed [4:0]             in_dynamic_prio,
  input  logic [4:0]                    in_static_prio,
  // result words
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [prqae_pkg::ID_W-1:0]    out_granted_id,
  output logic [prqae_pkg::PRIO_W-1:0]  out_assigned_prio,
  output logic                          out_to_expired,
  output logic                          out_banks_swapped
);

  localparam int SLOTS      = 2 * LEVELS;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LINK_DEPTH = (MAX_PROCESSES > prqae_pkg::ID_SPACE) ?
                              prqae_pkg::ID_SPACE : MAX_PROCESSES;
  localparam int PID_W      = $clog2(LINK_DEPTH);
  localparam int LIM_W      = (prqae_pkg::CFG_W > $clog2(LEVELS + 1)) ?
                              prqae_pkg::CFG_W : $clog2(LEVELS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_POP,
    S_LINK,
    S_DELIV
  } state_t;

  state_t                       state_r;
  logic [prqae_pkg::CFG_W-1:0]  num_levels_r;

  // per-word context
  logic [SLOT_W-1:0]            op_slot_r;
  logic [PID_W-1:0]             op_pid_r;
  logic [prqae_pkg::PRIO_W-1:0] op_prio_r;
  logic                         op_exp_r;
  logic                         op_swap_r;
  logic [PID_W-1:0]             op_tail_r;
  logic [PID_W-1:0]             op_id_r;

  prqae_pkg::result_t           res_r;
  prqae_pkg::result_t           out_res_r;
  logic                         out_valid_r;

  // Ids reduced modulo the process count: constant table
  logic [PID_W-1:0] id_map [prqae_pkg::ID_SPACE];
  for (genvar g = 0; g < prqae_pkg::ID_SPACE; g++) begin : g_id_map
    assign id_map[g] = PID_W'(g % MAX_PROCESSES);
  end

  // level map
  prqae_pkg::lvl_upd_t upd;
  prqae_pkg::lvl_sts_t sts;
  logic [SLOT_W-1:0]   upd_slot;
  logic                active_bank;
  logic                pop_bank;
  logic [SLOTS-1:0]    nonempty;
  logic [LVL_W-1:0]    pick_level;

  prqae_level_map #(
    .LEVELS (LEVELS)
  ) u_level_map (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (upd),
    .upd_slot    (upd_slot),
    .active_bank (active_bank),
    .pop_bank    (pop_bank),
    .nonempty    (nonempty),
    .sts         (sts),
    .pick_level  (pick_level)
  );

  // head/tail memory: {head, tail} per slot
  logic                   slot_we;
  logic [SLOT_W-1:0]      slot_raddr;
  logic [2*PID_W-1:0]     slot_wdata;
  logic [2*PID_W-1:0]     slot_rdata;
  logic [PID_W-1:0]       slot_head;
  logic [PID_W-1:0]       slot_tail;

  prqae_ram #(
    .WIDTH (2 * PID_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (op_slot_r),
    .wr_data (slot_wdata),
    .rd_addr (slot_raddr),
    .rd_data (slot_rdata)
  );

  assign slot_head = slot_rdata[2*PID_W-1:PID_W];
  assign slot_tail = slot_rdata[PID_W-1:0];

  // link memory: successor of each queued id
  logic             link_we;
  logic [PID_W-1:0] link_rdata;

  prqae_ram #(
    .WIDTH (PID_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (slot_tail),
    .wr_data (op_pid_r),
    .rd_addr (slot_head),
    .rd_data (link_rdata)
  );

  function automatic logic [SLOT_W-1:0] slot_of(input logic bank,
                                                input logic [LVL_W-1:0] lvl);
    return bank ? SLOT_W'(LEVELS) + SLOT_W'(lvl) : SLOT_W'(lvl);
  endfunction

  // --------------------------------------------------------------------------
  // Decode of the incoming word
  // --------------------------------------------------------------------------
  logic              accept;
  logic              is_take;
  logic              add_exp;
  logic signed [5:0] add_lvl_s;
  logic [LIM_W-1:0]  lim;
  logic              add_ok;
  logic [LVL_W-1:0]  add_level;
  logic              add_bank;
  logic [SLOT_W-1:0] add_slot;
  logic [SLOT_W-1:0] pop_slot;
  logic              take_empty;
  logic              take_swap;
  logic              out_free;

  assign accept   = in_valid && !in_stall;
  assign is_take  = (in_kind == prqae_pkg::KIND_TAKE);
  assign add_exp  = (in_dynamic_prio == prqae_pkg::DYN_EXPIRED);
  assign add_lvl_s = add_exp ? (signed'({1'b0, in_static_prio}) - 6'sd1)
                             : 6'(in_dynamic_prio);

  // Level count saturates at LEVELS
  assign lim = (LIM_W'(num_levels_r) > LIM_W'(LEVELS)) ? LIM_W'(LEVELS)
                                                       : LIM_W'(num_levels_r);
  assign add_ok    = !add_lvl_s[5] && (LIM_W'(add_lvl_s[4:0]) < lim);
  assign add_level = LVL_W'(add_lvl_s[4:0]);
  assign add_bank  = add_exp ? ~active_bank : active_bank;
  assign add_slot  = slot_of(add_bank, add_level);
  assign pop_slot  = slot_of(pop_bank, pick_level);

  assign take_empty = sts.act_empty && sts.exp_empty;
  assign take_swap  = sts.act_empty && !sts.exp_empty;

  assign slot_raddr = is_take ? pop_slot : add_slot;
  assign out_free   = !out_valid_r || !out_stall;

  // --------------------------------------------------------------------------
  // Memory updates and result of the finishing step
  // --------------------------------------------------------------------------
  logic               fin;
  prqae_pkg::result_t res_c;

  always_comb begin
    fin        = 1'b0;
    res_c      = '0;
    slot_we    = 1'b0;
    slot_wdata = {slot_head, op_pid_r};
    link_we    = 1'b0;
    upd        = '0;
    upd_slot   = op_slot_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_take) begin
            if (take_empty) begin
              fin          = 1'b1;
              res_c.status = prqae_pkg::ST_EMPTY;
            end else begin
              upd.swap = take_swap;
            end
          end else if (!add_ok) begin
            fin          = 1'b1;
            res_c.status = prqae_pkg::ST_RANGE;
          end
        end
      end
      S_ADD: begin
        // append behind the tail, or start a fresh list
        slot_we = 1'b1;
        if (nonempty[op_slot_r]) begin
          link_we    = 1'b1;
          slot_wdata = {slot_head, op_pid_r};
        end else begin
          slot_wdata = {op_pid_r, op_pid_r};
          upd.set    = 1'b1;
        end
        fin                 = 1'b1;
        res_c.status        = prqae_pkg::ST_ADDED;
        res_c.assigned_prio = op_prio_r;
        res_c.to_expired    = op_exp_r;
      end
      S_POP: begin
        // single entry: drop the level; else wait for the link read
        if (slot_head == slot_tail) begin
          upd.clr             = 1'b1;
          fin                 = 1'b1;
          res_c.status        = prqae_pkg::ST_GRANTED;
          res_c.granted_id    = prqae_pkg::ID_W'(slot_head);
          res_c.assigned_prio = op_prio_r;
          res_c.banks_swapped = op_swap_r;
        end
      end
      S_LINK: begin
        // advance the head to the successor
        slot_we             = 1'b1;
        slot_wdata          = {link_rdata, op_tail_r};
        fin                 = 1'b1;
        res_c.status        = prqae_pkg::ST_GRANTED;
        res_c.granted_id    = prqae_pkg::ID_W'(op_id_r);
        res_c.assigned_prio = op_prio_r;
        res_c.banks_swapped = op_swap_r;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer and output register
  // --------------------------------------------------------------------------
  logic out_load;

  // Load the output register from a finishing step or from the held result
  assign out_load = out_free && (fin || (state_r == S_DELIV));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // hold a stalled result, drop it once taken unless a new one loads
      out_valid_r <= out_load || (out_valid_r && out_stall);
      if (fin) begin
        if (out_free) begin
          out_res_r <= res_c;
          state_r   <= S_IDLE;
        end else begin
          res_r   <= res_c;
          state_r <= S_DELIV;
        end
      end else begin
        case (state_r)
          S_IDLE: begin
            if (accept) begin
              op_pid_r  <= id_map[in_process_id];
              op_exp_r  <= add_exp;
              op_swap_r <= take_swap;
              if (is_take) begin
                op_slot_r <= pop_slot;
                op_prio_r <= prqae_pkg::PRIO_W'(pick_level);
                state_r   <= S_POP;
              end else begin
                op_slot_r <= add_slot;
                op_prio_r <= prqae_pkg::PRIO_W'(add_level);
                state_r   <= S_ADD;
              end
            end
          end
          S_POP: begin
            op_tail_r <= slot_tail;
            op_id_r   <= slot_head;
            state_r   <= S_LINK;
          end
          S_DELIV: begin
            if (out_free) begin
              out_res_r <= res_r;
              state_r   <= S_IDLE;
            end
          end
          default: begin
            state_r <= S_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_levels_r <= prqae_pkg::NUM_LEVELS_RESET;
    end else if (cfg_we) begin
      num_levels_r <= cfg_wdata;
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_granted_id    = out_res_r.granted_id;
  assign out_assigned_prio = out_res_r.assigned_prio;
  assign out_to_expired    = out_res_r.to_expired;
  assign out_banks_swapped = out_res_r.banks_swapped;

`ifndef SYNTHESIS
  // The link read step only follows a pop that found more than one entry
  a_link_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LINK |-> $past(state_r) == S_POP)
    else $error("link step entered without a pop");

  // The banks swap only on an accepted take
  a_swap_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(active_bank)) |->
      $past(accept && is_take))
    else $error("active bank changed outside a take");

  // Popping the last entry of a level clears its nonempty mark
  a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP && slot_head == slot_tail) |=>
      !nonempty[$past(op_slot_r)])
    else $error("level still marked after popping its last entry");
`endif

endmodule

// ===== dv/priority_ready_queue_active_expired_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_ready_queue_active_expired_core_tb
// Self-checking bench for the active/expired ready-queue scheduler.
// An initial block fills a queue of add and take words, and a clocked driver
// feeds them to the block. Every accepted word runs through a bank, level and
// link-list model kept here, and the expected reply is queued. A clocked
// monitor checks each reply word in order, field by field. Both sides stall
// at random, and the level count changes between phases, extremes included.
// ----------------------------------------------------------------------------
module priority_ready_queue_active_expired_core_tb;

  localparam int NLVL           = prqae_pkg::DEF_LEVELS;
  localparam int ID_W           = prqae_pkg::ID_W;
  localparam int ID_SPACE       = prqae_pkg::ID_SPACE;
  localparam int PRIO_W         = prqae_pkg::PRIO_W;
  localparam int CFG_W          = prqae_pkg::CFG_W;
  localparam int WATCHDOG_LIMIT = 4000;

  // One input word as the driver presents it
  typedef struct {
    prqae_pkg::kind_t   kind;
    logic [ID_W-1:0]    pid;
    logic signed [4:0]  dyn;
    logic [4:0]         stat;
  } sched_word_t;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 cfg_we          = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata       = '0;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic                 in_kind         = 1'b0;
  logic [ID_W-1:0]      in_process_id   = '0;
  logic signed [4:0]    in_dynamic_prio = '0;
  logic [4:0]           in_static_prio  = '0;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic [1:0]           out_status;
  logic [ID_W-1:0]      out_granted_id;
  logic [PRIO_W-1:0]    out_assigned_prio;
  logic                 out_to_expired;
  logic                 out_banks_swapped;

  // Scheduler model: link table, per-slot head/tail, occupancy, active bank.
  // Slot bank*NLVL+level, same layout as the block.
  logic [ID_W-1:0]      rq_link [ID_SPACE];
  logic [ID_W-1:0]      rq_head [2*NLVL];
  logic [ID_W-1:0]      rq_tail [2*NLVL];
  logic [2*NLVL-1:0]    rq_busy   = '0;
  logic                 rq_bank   = 1'b0;
  logic [CFG_W-1:0]     rq_levels = prqae_pkg::NUM_LEVELS_RESET;

  sched_word_t          request_q [$];   // words not yet presented
  prqae_pkg::result_t   reply_q [$];     // expected replies, oldest first
  sched_word_t          cur_word;

  int send_idle_pct  = 10;
  int recv_idle_pct  = 66;
  int mismatches     = 0;
  int words_sent     = 0;
  int replies_seen   = 0;
  int swaps_seen     = 0;
  int status_cnt [4] = '{0, 0, 0, 0};
  int quiet_cycles   = 0;

  priority_ready_queue_active_expired_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_process_id     (in_process_id),
    .in_dynamic_prio   (in_dynamic_prio),
    .in_static_prio    (in_static_prio),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_granted_id    (out_granted_id),
    .out_assigned_prio (out_assigned_prio),
    .out_to_expired    (out_to_expired),
    .out_banks_swapped (out_banks_swapped)
  );

  always #10 clk = ~clk;

  // Append a word to the pending queue
  task automatic queue_word(input sched_word_t w);
    request_q.insert(request_q.size(), w);
  endtask

  // Advance the scheduler model by one accepted word and return its reply.
  task automatic serve_request(input sched_word_t w, output prqae_pkg::result_t r);
    int   lim;
    int   lvl;
    int   slot;
    int   base;
    logic to_exp;
    logic found;
    r     = '0;
    found = 1'b0;
    // Level counts above the bank depth saturate
    lim = (rq_levels > NLVL) ? NLVL : int'(rq_levels);
    if (w.kind == prqae_pkg::KIND_ADD) begin
      // Exhausted quantum: requeue in the expired bank at static-1
      to_exp = (w.dyn == prqae_pkg::DYN_EXPIRED);
      lvl    = to_exp ? int'(w.stat) - 1 : int'(w.dyn);
      if (lvl < 0 || lvl >= lim) begin
        r.status = prqae_pkg::ST_RANGE;
      end else begin
        slot = int'(rq_bank ^ to_exp) * NLVL + lvl;
        if (rq_busy[slot]) begin
          rq_link[rq_tail[slot]] = w.pid;
        end else begin
          rq_head[slot] = w.pid;
          rq_busy[slot] = 1'b1;
        end
        rq_tail[slot]   = w.pid;
        r.status        = prqae_pkg::ST_ADDED;
        r.assigned_prio = lvl[PRIO_W-1:0];
        r.to_expired    = to_exp;
      end
    end else if (rq_busy == '0) begin
      r.status = prqae_pkg::ST_EMPTY;
    end else begin
      base = int'(rq_bank) * NLVL;
      // Active bank drained: swap before the pop
      if (rq_busy[base +: NLVL] == '0) begin
        rq_bank         = ~rq_bank;
        base            = NLVL - base;
        r.banks_swapped = 1'b1;
      end
      // Scan all levels, including ones above the current level count
      for (int l = NLVL - 1; l >= 0; l--) begin
        if (!found && rq_busy[base + l]) begin
          found           = 1'b1;
          slot            = base + l;
          r.status        = prqae_pkg::ST_GRANTED;
          r.granted_id    = rq_head[slot];
          r.assigned_prio = l[PRIO_W-1:0];
          if (rq_head[slot] == rq_tail[slot]) begin
            rq_busy[slot] = 1'b0;
          end else begin
            rq_head[slot] = rq_link[rq_head[slot]];
          end
        end
      end
    end
  endtask

  // Driver: predict on acceptance, then load the next word or idle.
  always @(posedge clk) begin : drive_words
    prqae_pkg::result_t reply;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        serve_request(cur_word, reply);
        reply_q.insert(reply_q.size(), reply);
        words_sent++;
      end
      // Hold a stalled word; otherwise advance or drop valid for an idle cycle
      if (!in_valid || !in_stall) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_word        = request_q.pop_front();
          in_valid        <= 1'b1;
          in_kind         <= cur_word.kind;
          in_process_id   <= cur_word.pid;
          in_dynamic_prio <= cur_word.dyn;
          in_static_prio  <= cur_word.stat;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR reply %0d field %s: expected 0x%0h, got 0x%0h",
                 replies_seen, what, want, got);
      end
    end
  endtask

  // Monitor: compare every accepted reply word with the oldest expectation.
  always @(posedge clk) begin : check_replies
    prqae_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      replies_seen++;
      status_cnt[out_status]++;
      if (out_banks_swapped) begin
        swaps_seen++;
      end
      if (reply_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR reply %0d arrived with nothing expected", replies_seen);
        end
      end else begin
        want = reply_q.pop_front();
        check_field("status", want.status, out_status);
        check_field("granted_id", want.granted_id, out_granted_id);
        check_field("assigned_prio", want.assigned_prio, out_assigned_prio);
        check_field("to_expired", want.to_expired, out_to_expired);
        check_field("banks_swapped", want.banks_swapped, out_banks_swapped);
      end
    end
  end

  // Watchdog: end the run when no word moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d replies outstanding",
               WATCHDOG_LIMIT, reply_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Wait until every queued word has been accepted and answered, then let
  // the block settle before touching the level count.
  task automatic wait_drained();
    do @(negedge clk); while (request_q.size() != 0 || in_valid || reply_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_levels(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    rq_levels = value;
  endtask

  // Mostly well-formed adds at levels valid for the current count, plus takes
  // and raw-field adds as noise. Take words carry junk in the ignored fields.
  task automatic queue_random(input int count, input int take_pct);
    sched_word_t w;
    int          lim;
    int          roll;
    lim = (rq_levels > NLVL) ? NLVL : int'(rq_levels);
    repeat (count) begin
      w.kind = prqae_pkg::KIND_ADD;
      w.pid  = ID_W'($urandom);
      w.dyn  = 5'($urandom);
      w.stat = 5'($urandom);
      roll   = $urandom_range(0, 99);
      if (roll < take_pct) begin
        w.kind = prqae_pkg::KIND_TAKE;
      end else if (roll < 92 && lim > 0) begin
        if ($urandom_range(0, 2) == 0) begin
          w.dyn  = prqae_pkg::DYN_EXPIRED;
          w.stat = 5'($urandom_range(1, lim));
        end else begin
          w.dyn = 5'($urandom_range(0, lim - 1));
        end
      end
      queue_word(w);
    end
  endtask

  initial begin
    int lvl;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset level count of four
    queue_word('{prqae_pkg::KIND_TAKE, 8'h3C, 5'sd7, 5'd9});     // both banks empty
    queue_word('{prqae_pkg::KIND_ADD, 8'hA5, 5'sd0, 5'd0});      // lowest active level
    queue_word('{prqae_pkg::KIND_ADD, 8'h5A, 5'sd3, 5'd31});     // highest valid level
    queue_word('{prqae_pkg::KIND_ADD, 8'hFF, 5'sd4, 5'd2});      // level at the count
    queue_word('{prqae_pkg::KIND_ADD, 8'hFF, 5'sd15, 5'd2});     // largest positive level
    queue_word('{prqae_pkg::KIND_ADD, 8'h11, -5'sd2, 5'd2});     // just below expired code
    queue_word('{prqae_pkg::KIND_ADD, 8'h22, 5'b10000, 5'd2});   // most negative level
    queue_word('{prqae_pkg::KIND_ADD, 8'h00, prqae_pkg::DYN_EXPIRED, 5'd1});  // level 0
    queue_word('{prqae_pkg::KIND_ADD, 8'h81, prqae_pkg::DYN_EXPIRED, 5'd4});  // top level
    queue_word('{prqae_pkg::KIND_ADD, 8'h42, prqae_pkg::DYN_EXPIRED, 5'd0});  // static 0
    queue_word('{prqae_pkg::KIND_ADD, 8'h43, prqae_pkg::DYN_EXPIRED, 5'd5});  // above count
    queue_word('{prqae_pkg::KIND_ADD, 8'h44, prqae_pkg::DYN_EXPIRED, 5'd31}); // largest
    queue_word('{prqae_pkg::KIND_ADD, 8'h7E, 5'sd3, 5'd16});     // second in a level FIFO
    // Drain: FIFO order at level 3, then level 0, then swap into expired bank
    repeat (6) begin
      queue_word('{prqae_pkg::KIND_TAKE, 8'($urandom), 5'($urandom), 5'($urandom)});
    end
    wait_drained();

    // Full level count. Chain every id through one level so each link entry
    // gets written, re-queuing id 0 at the end, then pop the whole chain.
    write_levels(5'd16);
    lvl = $urandom_range(0, NLVL - 1);
    for (int i = 0; i < ID_SPACE; i++) begin
      queue_word('{prqae_pkg::KIND_ADD, ID_W'(i), 5'(lvl), 5'($urandom)});
    end
    queue_word('{prqae_pkg::KIND_ADD, '0, 5'(lvl), 5'($urandom)});
    repeat (ID_SPACE + 1) begin
      queue_word('{prqae_pkg::KIND_TAKE, ID_W'($urandom), 5'($urandom), 5'($urandom)});
    end
    queue_random(330, 40);
    wait_drained();

    // Zero levels: every add is rejected, leftovers are still served
    write_levels(5'd0);
    queue_random(40, 50);
    wait_drained();

    // Swap the idle pattern: slow sender, mostly ready receiver
    send_idle_pct = 66;
    recv_idle_pct = 10;
    write_levels(5'd31);     // saturates to the bank depth
    queue_random(330, 45);
    wait_drained();
    write_levels(5'd1);
    queue_random(120, 45);
    wait_drained();

    // Full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_levels(5'($urandom_range(1, NLVL)));
    queue_random(150, 45);
    wait_drained();
    write_levels(5'($urandom));
    queue_random(150, 55);
    wait_drained();
    repeat (12) @(posedge clk);

    $display("Covered %0d words over seven level counts: %0d adds, %0d rejected adds,",
             words_sent, status_cnt[prqae_pkg::ST_ADDED], status_cnt[prqae_pkg::ST_RANGE]);
    $display("%0d grants with %0d bank swaps, %0d takes on empty banks.",
             status_cnt[prqae_pkg::ST_GRANTED], swaps_seen,
             status_cnt[prqae_pkg::ST_EMPTY]);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
